// ===== rtl/qse_pkg.sv =====
// Shared constants and types for the quicksort engine.
package qse_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int STORE_DEPTH = 64;
    localparam int STACK_DEPTH = 64;
    localparam int VAL_W       = 32;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int SP_W        = 7;

    typedef struct packed {
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
    } t_range;

    typedef struct packed {
        logic   push;
        logic   pop;
        t_range range;
    } t_stk_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_stk_stat;

endpackage

// ===== rtl/qse_stack.sv =====
// Range stack: pending index ranges of the sort, one push or pop per cycle.
module qse_stack (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qse_pkg::t_stk_cmd  i_cmd,
    output qse_pkg::t_range    o_top,
    output qse_pkg::t_stk_stat o_stat
);

    qse_pkg::t_range                  r_mem [qse_pkg::STACK_DEPTH];
    qse_pkg::t_range                  r_top;
    logic [qse_pkg::SP_W-1:0]         r_sp;
    logic                             empty;
    logic                             full;
    logic [qse_pkg::SP_W-1:0]         sp_dec;

    assign empty  = (r_sp == '0);
    assign full   = (r_sp == qse_pkg::SP_W'(qse_pkg::STACK_DEPTH));
    assign sp_dec = r_sp - qse_pkg::SP_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (i_cmd.push && !full) begin
            r_sp <= r_sp + qse_pkg::SP_W'(1);
        end else if (i_cmd.pop && !empty) begin
            r_sp <= sp_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !full) begin
            r_mem[r_sp[qse_pkg::IDX_W-1:0]] <= i_cmd.range;
        end
        r_top <= r_mem[sp_dec[qse_pkg::IDX_W-1:0]];
    end

    assign o_top        = r_top;
    assign o_stat.empty = empty;
    assign o_stat.full  = full;

endmodule

// ===== rtl/quicksort_engine.sv =====
// Quicksort engine: loads signed words, sorts them in place, streams them out.
// Words are loaded one per cycle into a 64-entry store; the word marked last
// (which is dropped too if the store is full) starts an ascending in-place
// quicksort using Lomuto partitioning with the last entry of each range as
// pivot. The sort walks every element of a range with one shared compare
// unit over one store write port: each element is read and compared, and a
// swapped one takes a further write step; each partition pass adds pop,
// pivot read, final swap and push steps. The sorted words then leave one at
// a time, each held on the output until it is taken by the receiver. The
// input is not ready from the word marked last until the final sorted word is
// taken. o_overflowed is high on every word of a set that lost words.
module quicksort_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [qse_pkg::VAL_W-1:0]  i_item_value,
    input  logic                              i_is_last,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [qse_pkg::VAL_W-1:0]  o_sorted_value,
    output logic                              o_last_out,
    output logic                              o_overflowed
);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_POP, S_POPW, S_PIV, S_RD, S_CMP, S_SW2,
        S_FSW, S_FSW2, S_PUSH2, S_ERD, S_EOUT, S_EWAIT
    } t_state;

    t_state                             r_state;
    logic [qse_pkg::CNT_W-1:0]          r_count;
    logic                               r_ovf;
    logic [qse_pkg::IDX_W-1:0]          r_lo;
    logic [qse_pkg::IDX_W-1:0]          r_hi;
    logic [qse_pkg::IDX_W-1:0]          r_i;
    logic [qse_pkg::IDX_W-1:0]          r_j;
    logic [qse_pkg::IDX_W-1:0]          r_k;
    logic signed [qse_pkg::VAL_W-1:0]   r_pivot;
    logic signed [qse_pkg::VAL_W-1:0]   r_tmp;
    logic                               r_out_valid;
    logic signed [qse_pkg::VAL_W-1:0]   r_out_value;
    logic                               r_out_last;
    logic                               r_out_ovf;

    logic signed [qse_pkg::VAL_W-1:0]   r_store [qse_pkg::STORE_DEPTH];
    logic signed [qse_pkg::VAL_W-1:0]   r_rd_a;
    logic signed [qse_pkg::VAL_W-1:0]   r_rd_b;

    logic                               st_we;
    logic [qse_pkg::IDX_W-1:0]          st_waddr;
    logic signed [qse_pkg::VAL_W-1:0]   st_wdata;
    logic [qse_pkg::IDX_W-1:0]          ra_addr;
    logic [qse_pkg::IDX_W-1:0]          rb_addr;

    qse_pkg::t_stk_cmd                  stk_cmd;
    qse_pkg::t_range                    stk_top;
    qse_pkg::t_stk_stat                 stk_stat;

    logic                               has_room;
    logic                               is_less;
    logic                               push_right;
    logic                               push_left;
    logic                               at_final;

    assign has_room   = (r_count < qse_pkg::CNT_W'(qse_pkg::MAX_ITEMS));
    assign is_less    = (r_rd_a < r_pivot);
    assign push_right = ({1'b0, r_i} + 7'd1) < {1'b0, r_hi};
    assign push_left  = {1'b0, r_i} > ({1'b0, r_lo} + 7'd1);
    assign at_final   = (({1'b0, r_k} + qse_pkg::CNT_W'(1)) == r_count);

    qse_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stk_cmd),
        .o_top   (stk_top),
        .o_stat  (stk_stat)
    );

    // store port control and stack commands per sequencer step
    always_comb begin
        st_we         = 1'b0;
        st_waddr      = r_i;
        st_wdata      = r_tmp;
        ra_addr       = r_j;
        rb_addr       = r_i;
        stk_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                st_we    = i_valid && has_room;
                st_waddr = r_count[qse_pkg::IDX_W-1:0];
                st_wdata = i_item_value;
            end
            S_START: begin
                stk_cmd.push     = (r_count >= qse_pkg::CNT_W'(2));
                stk_cmd.range.lo = '0;
                stk_cmd.range.hi = qse_pkg::IDX_W'(r_count - qse_pkg::CNT_W'(1));
            end
            S_POP: begin
                stk_cmd.pop = 1'b1;
            end
            S_POPW: begin
                ra_addr = stk_top.hi;
            end
            S_RD: begin
                if (r_j < r_hi) begin
                    ra_addr = r_j;
                    rb_addr = r_i;
                end else begin
                    ra_addr = r_i;
                    rb_addr = r_hi;
                end
            end
            S_CMP: begin
                st_we    = is_less;
                st_waddr = r_i;
                st_wdata = r_rd_a;
            end
            S_SW2: begin
                st_we    = 1'b1;
                st_waddr = r_j;
                st_wdata = r_tmp;
            end
            S_FSW: begin
                st_we    = 1'b1;
                st_waddr = r_hi;
                st_wdata = r_rd_a;
            end
            S_FSW2: begin
                st_we            = 1'b1;
                st_waddr         = r_i;
                st_wdata         = r_tmp;
                stk_cmd.push     = push_right;
                stk_cmd.range.lo = r_i + qse_pkg::IDX_W'(1);
                stk_cmd.range.hi = r_hi;
            end
            S_PUSH2: begin
                stk_cmd.push     = push_left;
                stk_cmd.range.lo = r_lo;
                stk_cmd.range.hi = r_i - qse_pkg::IDX_W'(1);
            end
            S_ERD: begin
                ra_addr = r_k;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_waddr] <= st_wdata;
        end
        r_rd_a <= r_store[ra_addr];
        r_rd_b <= r_store[rb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (has_room) begin
                            r_count <= r_count + qse_pkg::CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_is_last) begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_k     <= '0;
                    r_state <= (r_count >= qse_pkg::CNT_W'(2)) ? S_POP : S_ERD;
                end
                S_POP: begin
                    if (stk_stat.empty) begin
                        r_k     <= '0;
                        r_state <= S_ERD;
                    end else begin
                        r_state <= S_POPW;
                    end
                end
                S_POPW: begin
                    r_lo    <= stk_top.lo;
                    r_hi    <= stk_top.hi;
                    r_i     <= stk_top.lo;
                    r_j     <= stk_top.lo;
                    r_state <= (stk_top.lo >= stk_top.hi) ? S_POP : S_PIV;
                end
                S_PIV: begin
                    r_pivot <= r_rd_a;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= (r_j < r_hi) ? S_CMP : S_FSW;
                end
                S_CMP: begin
                    if (is_less) begin
                        r_tmp   <= r_rd_b;
                        r_state <= S_SW2;
                    end else begin
                        r_j     <= r_j + qse_pkg::IDX_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_SW2: begin
                    r_i     <= r_i + qse_pkg::IDX_W'(1);
                    r_j     <= r_j + qse_pkg::IDX_W'(1);
                    r_state <= S_RD;
                end
                S_FSW: begin
                    r_tmp   <= r_rd_b;
                    r_state <= S_FSW2;
                end
                S_FSW2: begin
                    r_state <= S_PUSH2;
                end
                S_PUSH2: begin
                    r_state <= S_POP;
                end
                S_ERD: begin
                    r_state <= S_EOUT;
                end
                S_EOUT: begin
                    r_out_valid <= 1'b1;
                    r_out_value <= r_rd_a;
                    r_out_last  <= at_final;
                    r_out_ovf   <= r_ovf;
                    r_state     <= S_EWAIT;
                end
                S_EWAIT: begin
                    if (i_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + qse_pkg::IDX_W'(1);
                            r_state <= S_ERD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_last_out     = r_out_last;
    assign o_overflowed   = r_out_ovf;

    // each pushed range owns at least two values, so the stack cannot fill
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_cmd.push |-> !stk_stat.full)
        else $error("range stack push while full");

    a_part_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_CMP || r_state == S_SW2)
            |-> (r_i <= r_j && r_j <= r_hi && r_lo <= r_i))
        else $error("partition indexes out of order");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_count != '0 && {1'b0, r_k} < r_count))
        else $error("word emitted beyond stored set");

    a_set_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_out) |=> (o_ready && r_count == '0 && !r_ovf))
        else $error("set not cleared after final word");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the quicksort engine: random sets in, sorted words out.

typedef struct {
    logic signed [qse_pkg::VAL_W-1:0] value;
    logic                             last;
    logic                             lossy;
} t_sorted_word;

class sort_ledger;
    logic signed [qse_pkg::VAL_W-1:0] held [qse_pkg::STORE_DEPTH];
    int           held_cnt;
    bit           dropped;
    t_sorted_word sorted_due [$];
    int           errors;
    int           sets;
    int           lossy_sets;
    int           words_in;
    int           words_out;

    function new();
        held_cnt   = 0;
        dropped    = 1'b0;
        errors     = 0;
        sets       = 0;
        lossy_sets = 0;
        words_in   = 0;
        words_out  = 0;
    endfunction

    function int pending();
        return sorted_due.size();
    endfunction

    // Lomuto pass: pivot is the top entry of the range, returns its final slot
    function int split_range(int lo, int hi);
        logic signed [qse_pkg::VAL_W-1:0] pivot;
        logic signed [qse_pkg::VAL_W-1:0] t;
        int i;
        int j;
        pivot = held[hi];
        i = lo;
        for (j = lo; j < hi; j++) begin
            if (held[j] < pivot) begin
                t       = held[i];
                held[i] = held[j];
                held[j] = t;
                i++;
            end
        end
        t        = held[i];
        held[i]  = held[hi];
        held[hi] = t;
        return i;
    endfunction

    function void quicksort_held();
        qse_pkg::t_range ranges [$];
        qse_pkg::t_range r;
        qse_pkg::t_range part;
        int p;
        int lo;
        int hi;
        if (held_cnt < 2) return;
        r.lo = '0;
        r.hi = qse_pkg::IDX_W'(held_cnt - 1);
        ranges.push_back(r);
        while (ranges.size() > 0) begin
            r  = ranges.pop_back();
            lo = int'(r.lo);
            hi = int'(r.hi);
            if (lo >= hi) continue;
            p = split_range(lo, hi);
            // upper part goes on first so the lower part is taken next
            if (p + 1 < hi) begin
                part.lo = qse_pkg::IDX_W'(p + 1);
                part.hi = qse_pkg::IDX_W'(hi);
                ranges.push_back(part);
            end
            if (p > lo + 1) begin
                part.lo = qse_pkg::IDX_W'(lo);
                part.hi = qse_pkg::IDX_W'(p - 1);
                ranges.push_back(part);
            end
        end
    endfunction

    function void take_word(logic signed [qse_pkg::VAL_W-1:0] v, logic last);
        t_sorted_word w;
        int k;
        words_in++;
        if (held_cnt < qse_pkg::MAX_ITEMS) begin
            held[held_cnt] = v;
            held_cnt++;
        end else begin
            dropped = 1'b1;
        end
        if (!last) return;
        quicksort_held();
        for (k = 0; k < held_cnt; k++) begin
            w.value = held[k];
            w.last  = (k == held_cnt - 1);
            w.lossy = dropped;
            sorted_due.push_back(w);
        end
        sets++;
        if (dropped) lossy_sets++;
        held_cnt = 0;
        dropped  = 1'b0;
    endfunction

    function void check_word(logic signed [qse_pkg::VAL_W-1:0] v, logic last, logic lossy);
        t_sorted_word exp;
        words_out++;
        if (sorted_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected sorted word: expected none, got %0d", $time, v);
            return;
        end
        exp = sorted_due.pop_front();
        if (v !== exp.value) begin
            errors++;
            $display("%0t: sorted_value mismatch: expected %0d, got %0d", $time, exp.value, v);
        end
        if (last !== exp.last) begin
            errors++;
            $display("%0t: last_out mismatch: expected %0b, got %0b", $time, exp.last, last);
        end
        if (lossy !== exp.lossy) begin
            errors++;
            $display("%0t: overflowed mismatch: expected %0b, got %0b", $time, exp.lossy, lossy);
        end
    endfunction
endclass

module testbench;

    typedef logic signed [qse_pkg::VAL_W-1:0] t_word_q [$];

    typedef enum int {
        FILL_RANDOM,
        FILL_NARROW,
        FILL_RISING,
        FILL_FALLING,
        FILL_EXTREME
    } t_fill;

    localparam logic signed [qse_pkg::VAL_W-1:0] WORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [qse_pkg::VAL_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam int TOTAL_WORDS = 360;
    localparam int STUCK_LIMIT = 60000;
    localparam int TAIL_CYCLES = 200;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_ready;
    logic signed [qse_pkg::VAL_W-1:0] i_item_value;
    logic                             i_is_last;
    logic                             o_valid;
    logic                             i_ready;
    logic signed [qse_pkg::VAL_W-1:0] o_sorted_value;
    logic                             o_last_out;
    logic                             o_overflowed;

    sort_ledger book = new();
    int         stuck = 0;

    quicksort_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_item_value   (i_item_value),
        .i_is_last      (i_is_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_overflowed   (o_overflowed)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [qse_pkg::VAL_W-1:0] pick_word(t_fill mode, int k,
                                                                   logic signed [31:0] base);
        case (mode)
            FILL_RANDOM:  return $urandom;
            FILL_NARROW:  return $urandom_range(0, 8) - 4;
            FILL_RISING:  return base + k * 3;
            FILL_FALLING: return base - k;
            default: begin
                case ($urandom_range(0, 4))
                    0:       return WORD_MIN;
                    1:       return WORD_MAX;
                    2:       return '0;
                    3:       return -1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    task automatic send_word(logic signed [qse_pkg::VAL_W-1:0] v, logic last, bit calm);
        int gap;
        gap = calm ? 0 : idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_item_value <= v;
        i_is_last    <= last;
        i_valid      <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        book.take_word(v, last);
    endtask

    task automatic send_set(t_word_q words, bit calm);
        foreach (words[k]) send_word(words[k], k == words.size() - 1, calm);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
    endtask

    // result side: stalls of random length, with some long stretches of no stall
    initial begin : receiver
        int left;
        left    = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (left > 0) begin
                left--;
            end else if (!i_ready) begin
                i_ready <= 1'b1;
                left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(0, 5);
            end else begin
                left = idle_len();
                if (left > 0) begin
                    i_ready <= 1'b0;
                    left--;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid && i_ready)
            book.check_word(o_sorted_value, o_last_out, o_overflowed);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
    end

    initial begin : watchdog
        wait (stuck >= STUCK_LIMIT);
        $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        t_word_q words;
        int      set_no;
        int      n;
        int      r;
        int      k;
        t_fill   mode;
        bit      calm;
        logic signed [31:0] base;

        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_item_value = '0;
        i_is_last    = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single word, both extremes, mixed signs, duplicates, presorted runs
        words = '{WORD_MAX};
        send_set(words, 1'b0);
        words = '{WORD_MAX, WORD_MIN};
        send_set(words, 1'b0);
        words = '{32'sd0, -32'sd1, 32'sd1, WORD_MIN, WORD_MAX};
        send_set(words, 1'b1);
        words = '{32'sd7, 32'sd7, 32'sd7};
        send_set(words, 1'b0);
        words = '{32'sd1, 32'sd2, 32'sd3, 32'sd4};
        send_set(words, 1'b0);
        words = '{-32'sd1, -32'sd2, -32'sd3, -32'sd4};
        send_set(words, 1'b0);
        wait_for_results();

        set_no = 0;
        while (book.words_in < TOTAL_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 75)      n = $urandom_range(1, 10);
            else if (r < 92) n = $urandom_range(11, 32);
            else if (r < 97) n = qse_pkg::MAX_ITEMS;
            else             n = $urandom_range(qse_pkg::MAX_ITEMS + 1, qse_pkg::MAX_ITEMS + 4);
            mode = t_fill'($urandom_range(0, 4));
            // full set whose last word is dropped, worst-case presorted full set,
            // and a set that loses several words
            if (set_no == 2) n = qse_pkg::MAX_ITEMS + 1;
            if (set_no == 5) begin
                n    = qse_pkg::MAX_ITEMS;
                mode = FILL_RISING;
            end
            if (set_no == 8) n = qse_pkg::MAX_ITEMS + 6;
            base = (mode == FILL_RISING || mode == FILL_FALLING) && $urandom_range(0, 1)
                   ? $urandom_range(0, 200) - 100 : $urandom;
            calm = ($urandom_range(0, 4) == 0);
            words.delete();
            for (k = 0; k < n; k++) words.push_back(pick_word(mode, k, base));
            send_set(words, calm);
            set_no++;
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sorted %0d sets (%0d of them lost words to a full store).",
                 book.sets, book.lossy_sets);
        $display("Loaded %0d words, checked %0d sorted words, %0d errors.",
                 book.words_in, book.words_out, book.errors);
        if (book.errors == 0 && book.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d sorted words never arrived", book.pending());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
